// ===== design/rcnw_pkg.sv =====
// Shared constants for the raster causal-neighbor line buffer.
// No dependencies; the top level refers to it by scoped names.
package rcnw_pkg;

  // Fixed field widths of the ports.
  localparam int CFG_W = 13;
  localparam int PIX_W = 8;

  // Line width that takes effect after reset, capped at MAX_WIDTH by the top level.
  localparam int RESET_WIDTH = 4096;

  // Defaults for the top-level parameters.
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int PIXEL_BITS_DEF = 8;

endpackage

// ===== design/rcnw_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies; used for every line-store memory in the block.
module rcnw_ram #(
  parameter  int WIDTH  = 8,
  parameter  int DEPTH  = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data register holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/rcnw_line_store.sv =====
// Two-row line store: the above and above-right reads plus the current-row write.
// Depends on rcnw_ram; a per-bank fill count stands in for clearing the memories.
module rcnw_line_store #(
  parameter  int MAX_WIDTH  = 4096,
  parameter  int PIXEL_BITS = 8,
  localparam int COL_W      = $clog2(MAX_WIDTH),
  localparam int CNT_W      = COL_W + 1,
  localparam int DEPTH      = 2 * MAX_WIDTH,
  localparam int ADDR_W     = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  acc,
  input  logic                  up_sel,
  input  logic [COL_W-1:0]      col,
  input  logic                  last,
  input  logic [PIXEL_BITS-1:0] wr_pixel,
  output logic [PIXEL_BITS-1:0] rd_above,
  output logic [PIXEL_BITS-1:0] rd_above_right
);

  logic [CNT_W-1:0]      fill [2];
  logic [CNT_W-1:0]      col_ext;
  logic [CNT_W-1:0]      col_p1;
  logic                  cur_sel;
  logic [ADDR_W-1:0]     up_base;
  logic [ADDR_W-1:0]     cur_base;
  logic [ADDR_W-1:0]     addr_b;
  logic [ADDR_W-1:0]     addr_d;
  logic [ADDR_W-1:0]     addr_w;
  logic                  b_ok;
  logic                  d_ok;
  logic [PIXEL_BITS-1:0] ram_b_q;
  logic [PIXEL_BITS-1:0] ram_d_q;

  // Bank bases and addresses; the above row lives in the bank picked by up_sel.
  always_comb begin
    col_ext  = CNT_W'(col);
    col_p1   = col_ext + CNT_W'(1);
    cur_sel  = ~up_sel;
    up_base  = up_sel ? ADDR_W'(MAX_WIDTH) : '0;
    cur_base = cur_sel ? ADDR_W'(MAX_WIDTH) : '0;
    addr_b   = up_base + ADDR_W'(col_ext);
    addr_d   = up_base + ADDR_W'(col_p1);
    addr_w   = cur_base + ADDR_W'(col_ext);
  end

  // Copy of the line store serving the pixel directly above.
  rcnw_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (acc),
    .waddr (addr_w),
    .wdata (wr_pixel),
    .re    (acc),
    .raddr (addr_b),
    .rdata (ram_b_q)
  );

  // Second copy serving the pixel above and to the right.
  rcnw_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_ram_d (
    .clk   (clk),
    .we    (acc),
    .waddr (addr_w),
    .wdata (wr_pixel),
    .re    (acc),
    .raddr (addr_d),
    .rdata (ram_d_q)
  );

  // Each row write runs from column zero upward, so the written part of a
  // bank is always a prefix; fill marks its end and anything past it reads zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill[0] <= '0;
      fill[1] <= '0;
    end else if (acc && (col_ext >= fill[cur_sel])) begin
      fill[cur_sel] <= col_p1;
    end
  end

  // Validity of the two reads, taken alongside the read data.
  always_ff @(posedge clk) begin
    if (acc) begin
      b_ok <= col_ext < fill[up_sel];
      d_ok <= !last && (col_p1 < fill[up_sel]);
    end
  end

  assign rd_above       = b_ok ? ram_b_q : '0;
  assign rd_above_right = d_ok ? ram_d_q : '0;

  // The fill count never passes the row length.
  a_fill_range : assert property (@(posedge clk) disable iff (rst)
    (fill[0] <= CNT_W'(MAX_WIDTH)) && (fill[1] <= CNT_W'(MAX_WIDTH)))
    else $error("line store fill count beyond row length");

  // A write never lands past the end of the written prefix.
  a_fill_contig : assert property (@(posedge clk) disable iff (rst)
    acc |-> (col_ext <= fill[cur_sel]))
    else $error("line store write leaves a gap in the row");

endmodule

// ===== design/raster_context_neighbor_window_top.sv =====
// Top level of the raster causal-neighbor line buffer: column tracking,
// pipeline control and the output register. Depends on rcnw_pkg and rcnw_line_store.
//
//   channel  | signals                                        | role
//   ---------+------------------------------------------------+-------------------
//   input    | in_valid, in_stall, pixel                      | one pixel/transfer
//   output   | out_valid, out_stall, left, above, above_left, | neighbors of that
//            | above_right, line_end                          | pixel
//   config   | cfg_wr_en, image_width                         | row width write
//
// One pixel per clock is taken when the output side keeps up; each pixel costs
// one read on each of the two line-store memories and one write to both.
// A pixel passes the registered memory read and then the output register
// on its way from input transfer to output transfer.
// Reset is synchronous; the memories are not cleared, a per-bank fill count
// makes unwritten entries read as zero, so pixels are taken right after reset.
// An output stall backs up into in_stall once the read stage is also full.
module raster_context_neighbor_window_top #(
  parameter  int MAX_WIDTH  = rcnw_pkg::MAX_WIDTH_DEF,
  parameter  int PIXEL_BITS = rcnw_pkg::PIXEL_BITS_DEF,
  localparam int COL_W      = $clog2(MAX_WIDTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [rcnw_pkg::CFG_W-1:0] image_width,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [rcnw_pkg::PIX_W-1:0] pixel,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rcnw_pkg::PIX_W-1:0] left,
  output logic [rcnw_pkg::PIX_W-1:0] above,
  output logic [rcnw_pkg::PIX_W-1:0] above_left,
  output logic [rcnw_pkg::PIX_W-1:0] above_right,
  output logic                       line_end
);

  localparam int WIDE_W = (COL_W + 1 > rcnw_pkg::CFG_W) ? COL_W + 1 : rcnw_pkg::CFG_W;
  localparam int RESET_W =
    (rcnw_pkg::RESET_WIDTH < MAX_WIDTH) ? rcnw_pkg::RESET_WIDTH : MAX_WIDTH;

  logic [COL_W-1:0]      last_col;
  logic [COL_W-1:0]      last_col_next;
  logic [WIDE_W-1:0]     cfg_wide;
  logic [COL_W-1:0]      column;
  logic                  row_select;
  logic [PIXEL_BITS-1:0] prev_pixel;
  logic [PIXEL_BITS-1:0] pix_in;
  logic                  acc;
  logic                  last;
  logic                  s1_valid;
  logic                  s1_move;
  logic [PIXEL_BITS-1:0] s1_left;
  logic                  s1_col_nz;
  logic                  s1_last;
  logic [PIXEL_BITS-1:0] last_above;
  logic [PIXEL_BITS-1:0] rd_above;
  logic [PIXEL_BITS-1:0] rd_above_right;

  // Width register holds the last column index, with zero and oversize widths clamped.
  always_comb begin
    cfg_wide = WIDE_W'(image_width);
    if (cfg_wide == '0) begin
      last_col_next = '0;
    end else if (cfg_wide > WIDE_W'(MAX_WIDTH)) begin
      last_col_next = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col_next = COL_W'(cfg_wide - WIDE_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= COL_W'(RESET_W - 1);
    end else if (cfg_wr_en) begin
      last_col <= last_col_next;
    end
  end

  // Handshake: the read stage moves on whenever the output register is free
  // or being emptied this cycle.
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;
  assign acc      = in_valid && !in_stall;
  assign last     = column >= last_col;
  assign pix_in   = PIXEL_BITS'(pixel);

  // Column counter and row bank selection.
  always_ff @(posedge clk) begin
    if (rst) begin
      column     <= '0;
      row_select <= 1'b0;
    end else if (acc) begin
      if (last) begin
        column     <= '0;
        row_select <= ~row_select;
      end else begin
        column <= column + COL_W'(1);
      end
    end
  end

  // The left neighbor is the previous pixel of the same row, so it comes
  // from a register instead of the memory.
  always_ff @(posedge clk) begin
    if (acc) begin
      prev_pixel <= pix_in;
    end
  end

  rcnw_line_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line_store (
    .clk            (clk),
    .rst            (rst),
    .acc            (acc),
    .up_sel         (row_select),
    .col            (column),
    .last           (last),
    .wr_pixel       (pix_in),
    .rd_above       (rd_above),
    .rd_above_right (rd_above_right)
  );

  // Read stage: control valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // Read stage: side data that travels with the memory read.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_left   <= (column != '0) ? prev_pixel : '0;
      s1_col_nz <= column != '0;
      s1_last   <= last;
    end
  end

  // The above-left neighbor equals the above neighbor of the previous pixel.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      last_above <= rd_above;
    end
  end

  // Output register: control valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      left        <= rcnw_pkg::PIX_W'(s1_left);
      above       <= rcnw_pkg::PIX_W'(rd_above);
      above_left  <= s1_col_nz ? rcnw_pkg::PIX_W'(last_above) : '0;
      above_right <= rcnw_pkg::PIX_W'(rd_above_right);
      line_end    <= s1_last;
    end
  end

  // Input is held off only while the read stage is occupied.
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with an empty read stage");

  // An accepted pixel always occupies the read stage in the next cycle.
  a_acc_fills : assert property (@(posedge clk) disable iff (rst)
    acc |=> s1_valid)
    else $error("accepted pixel missing from read stage");

  // A read stage that drains with nothing new behind it becomes empty.
  a_drain : assert property (@(posedge clk) disable iff (rst)
    (s1_move && !acc) |=> !s1_valid)
    else $error("read stage kept a pixel after it moved on");

  // The column stays inside the row store.
  a_col_range : assert property (@(posedge clk) disable iff (rst)
    column <= COL_W'(MAX_WIDTH - 1))
    else $error("column beyond the row store");

endmodule
